/* hw/rtl/mm4_pkg.sv */
`default_nettype none
package mm4_pkg;

    localparam int DATA_W         = 32;
    localparam int PROD_W         = 2 * DATA_W;
    localparam int ACC_W          = PROD_W + 2;
    localparam int POS_W          = 5;
    localparam int IDX_W          = 4;
    localparam int K_W            = 2;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(31);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(15);
    localparam logic [K_W-1:0]   K_FIRST  = K_W'(0);
    localparam logic [K_W-1:0]   K_LAST   = K_W'(3);

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_WAIT  = 3'b100
    } t_state;

endpackage
`default_nettype wire

/* hw/rtl/matrix4x4_multiply.sv */
// Loads 32 elements at one per cycle (A then B, row-major) with o_stall low.
// After the 32nd item the 16 products come out row-major, one at a time, from
// a single shared multiply-accumulate unit; the next product is not started
// until the previous one has been taken.
// Input is stalled while products are formed. Synchronous active-low reset
// clears the control state and the load position; the operand store is not reset.
`default_nettype none
module matrix4x4_multiply #(
    parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire  [mm4_pkg::DATA_W-1:0]      i_element_value,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic [mm4_pkg::DATA_W-1:0]      o_product_value,
    output logic [mm4_pkg::IDX_W-1:0]       o_product_index,
    output logic                            o_is_last
);

    mm4_pkg::t_state                    r_state, n_state;
    logic [mm4_pkg::POS_W-1:0]          r_pos, n_pos;
    logic [mm4_pkg::IDX_W-1:0]          r_idx, n_idx;
    logic [mm4_pkg::K_W-1:0]            r_k, n_k;

    logic [mm4_pkg::DATA_W-1:0]         r_mem [2**mm4_pkg::POS_W];
    logic [mm4_pkg::DATA_W-1:0]         r_rd_a;
    logic [mm4_pkg::DATA_W-1:0]         r_rd_b;
    mm4_pkg::t_mac_ctl                  r_rd_ctl;
    mm4_pkg::t_mac_ctl                  n_rd_ctl;

    logic                               r_out_valid;
    logic [mm4_pkg::DATA_W-1:0]         r_out_value;
    logic [mm4_pkg::IDX_W-1:0]          r_out_index;
    logic                               r_out_last;

    logic                               in_take;
    logic                               out_take;
    logic                               mac_done;
    logic [mm4_pkg::DATA_W-1:0]         mac_result;
    logic [mm4_pkg::POS_W-1:0]          addr_a;
    logic [mm4_pkg::POS_W-1:0]          addr_b;

    assign in_take  = i_valid && (r_state == mm4_pkg::ST_LOAD);
    assign out_take = r_out_valid && !i_stall;
    assign addr_a   = {1'b0, r_idx[3:2], r_k};
    assign addr_b   = {1'b1, r_k, r_idx[1:0]};

    always_comb begin
        n_state        = r_state;
        n_pos          = r_pos;
        n_idx          = r_idx;
        n_k            = r_k;
        n_rd_ctl       = '0;
        unique case (r_state)
            mm4_pkg::ST_LOAD: begin
                if (in_take) begin
                    n_pos = r_pos + 1'b1;
                    if (r_pos == mm4_pkg::POS_LAST) begin
                        n_state = mm4_pkg::ST_ISSUE;
                        n_idx   = '0;
                        n_k     = mm4_pkg::K_FIRST;
                    end
                end
            end
            mm4_pkg::ST_ISSUE: begin
                n_rd_ctl.valid = 1'b1;
                n_rd_ctl.first = (r_k == mm4_pkg::K_FIRST);
                n_rd_ctl.last  = (r_k == mm4_pkg::K_LAST);
                n_k            = r_k + 1'b1;
                if (r_k == mm4_pkg::K_LAST) begin
                    n_state = mm4_pkg::ST_WAIT;
                end
            end
            mm4_pkg::ST_WAIT: begin
                if (out_take) begin
                    if (r_idx == mm4_pkg::IDX_LAST) begin
                        n_state = mm4_pkg::ST_LOAD;
                    end else begin
                        n_state = mm4_pkg::ST_ISSUE;
                        n_idx   = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = mm4_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mm4_pkg::ST_LOAD;
            r_pos       <= '0;
            r_idx       <= '0;
            r_k         <= '0;
            r_rd_ctl    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_idx    <= n_idx;
            r_k      <= n_k;
            r_rd_ctl <= n_rd_ctl;
            if (mac_done) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mem[r_pos] <= i_element_value;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (mac_done) begin
            r_out_value <= mac_result;
            r_out_index <= r_idx;
            r_out_last  <= (r_idx == mm4_pkg::IDX_LAST);
        end
    end

    mm4_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_rd_ctl),
        .i_a      (r_rd_a),
        .i_b      (r_rd_b),
        .o_done   (mac_done),
        .o_result (mac_result)
    );

    assign o_stall         = (r_state != mm4_pkg::ST_LOAD);
    assign o_valid         = r_out_valid;
    assign o_product_value = r_out_value;
    assign o_product_index = r_out_index;
    assign o_is_last       = r_out_last;

endmodule
`default_nettype wire

/* hw/rtl/mm4_mac.sv */
`default_nettype none
module mm4_mac #(
    parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire  mm4_pkg::t_mac_ctl         i_ctl,
    input  wire  [mm4_pkg::DATA_W-1:0]      i_a,
    input  wire  [mm4_pkg::DATA_W-1:0]      i_b,
    output logic                            o_done,
    output logic [mm4_pkg::DATA_W-1:0]      o_result
);

    localparam int HI_W = mm4_pkg::ACC_W - mm4_pkg::DATA_W + 1;

    mm4_pkg::t_mac_ctl                  r_p_ctl;
    logic signed [mm4_pkg::PROD_W-1:0]  r_prod;
    logic                               r_acc_done;
    logic signed [mm4_pkg::ACC_W-1:0]   r_acc;
    logic                               r_done;
    logic [mm4_pkg::DATA_W-1:0]         r_result;

    logic signed [mm4_pkg::ACC_W-1:0]   n_acc;
    logic signed [mm4_pkg::ACC_W-1:0]   prod_ext;
    logic signed [mm4_pkg::ACC_W-1:0]   shifted;
    logic [HI_W-1:0]                    shifted_hi;
    logic [mm4_pkg::DATA_W-1:0]         n_result;

    always_comb begin
        prod_ext = mm4_pkg::ACC_W'(r_prod);
        n_acc    = r_p_ctl.first ? prod_ext : r_acc + prod_ext;
    end

    always_comb begin
        shifted    = r_acc >>> FRAC_BITS;
        shifted_hi = shifted[mm4_pkg::ACC_W-1:mm4_pkg::DATA_W-1];
        if ((&shifted_hi) || !(|shifted_hi)) begin
            n_result = shifted[mm4_pkg::DATA_W-1:0];
        end else if (shifted[mm4_pkg::ACC_W-1]) begin
            n_result = mm4_pkg::SAT_MIN;
        end else begin
            n_result = mm4_pkg::SAT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl    <= '0;
            r_acc_done <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_p_ctl    <= i_ctl;
            r_acc_done <= r_p_ctl.valid && r_p_ctl.last;
            r_done     <= r_acc_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_a) * $signed(i_b);
        if (r_p_ctl.valid) begin
            r_acc <= n_acc;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
`default_nettype wire

/* tb/sv/tb_matrix4x4_multiply.sv */
`timescale 1ns / 100ps
module tb_matrix4x4_multiply;

    localparam int ROW_STRIDE = 4;
    localparam int B_BASE = 16;
    localparam int PAIRS_RANDOM = 4;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD = 400;
    localparam logic [mm4_pkg::DATA_W-1:0] ONE_Q = 32'h0001_0000;
    localparam logic [mm4_pkg::DATA_W-1:0] MINUS_LSB = 32'hFFFF_FFFF;
    localparam logic signed [mm4_pkg::ACC_W-1:0] ACC_MAX =
        $signed({{(mm4_pkg::ACC_W-mm4_pkg::DATA_W){1'b0}}, mm4_pkg::SAT_MAX});
    localparam logic signed [mm4_pkg::ACC_W-1:0] ACC_MIN =
        $signed({{(mm4_pkg::ACC_W-mm4_pkg::DATA_W){1'b1}}, mm4_pkg::SAT_MIN});

    typedef struct {
        logic [mm4_pkg::DATA_W-1:0] value;
        logic [mm4_pkg::IDX_W-1:0]  index;
        logic                       last;
    } t_product;

    typedef enum int {
        FILL_FULL,
        FILL_SMALL,
        FILL_MEDIUM,
        FILL_CORNER,
        FILL_MIXED
    } t_fill_mode;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       i_stall = 1'b0;
    logic [mm4_pkg::DATA_W-1:0] i_element_value = '0;
    logic                       o_stall;
    logic                       o_valid;
    logic [mm4_pkg::DATA_W-1:0] o_product_value;
    logic [mm4_pkg::IDX_W-1:0]  o_product_index;
    logic                       o_is_last;

    logic [mm4_pkg::DATA_W-1:0] element_queue[$];
    t_product                   expected_products[$];
    logic [mm4_pkg::DATA_W-1:0] operand_copy[32];
    logic [mm4_pkg::POS_W-1:0]  load_pos = '0;
    bit                         in_taken = 1'b0;
    int                         errors = 0;
    int                         products_seen = 0;
    int                         idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    matrix4x4_multiply i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_element_value (i_element_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_product_value (o_product_value),
        .o_product_index (o_product_index),
        .o_is_last       (o_is_last)
    );

    function automatic logic [mm4_pkg::DATA_W-1:0] dot_row_col(int r, int c);
        logic signed [mm4_pkg::ACC_W-1:0]  sum;
        logic signed [mm4_pkg::PROD_W-1:0] prod;
        sum = '0;
        for (int k = 0; k < 4; k++) begin
            prod = $signed(operand_copy[r * ROW_STRIDE + k])
                 * $signed(operand_copy[B_BASE + k * ROW_STRIDE + c]);
            sum = sum + prod;
        end
        sum = sum >>> mm4_pkg::FRAC_BITS_DEF;
        if (sum > ACC_MAX) begin
            return mm4_pkg::SAT_MAX;
        end
        if (sum < ACC_MIN) begin
            return mm4_pkg::SAT_MIN;
        end
        return sum[mm4_pkg::DATA_W-1:0];
    endfunction

    function automatic logic [mm4_pkg::DATA_W-1:0] random_element(t_fill_mode mode);
        int         v;
        t_fill_mode pick;
        pick = mode;
        if (pick == FILL_MIXED) begin
            pick = t_fill_mode'($urandom_range(0, 3));
        end
        case (pick)
            FILL_SMALL: begin
                v = int'($urandom_range(0, 1 << 20)) - (1 << 19);
                return v;
            end
            FILL_MEDIUM: begin
                v = int'($urandom_range(0, 1 << 25)) - (1 << 24);
                return v;
            end
            FILL_CORNER: begin
                case ($urandom_range(0, 5))
                    0: return mm4_pkg::SAT_MIN;
                    1: return mm4_pkg::SAT_MAX;
                    2: return '0;
                    3: return MINUS_LSB;
                    4: return ONE_Q;
                    default: return 32'd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // predict and check at the rising edge
    always @(posedge i_clk) begin
        t_product want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && !o_stall;
            if (o_valid && !i_stall) begin
                products_seen++;
                if (expected_products.size() == 0) begin
                    $display("%0t: unexpected product index %0d value %08h", $time,
                             o_product_index, o_product_value);
                    errors++;
                end else begin
                    want = expected_products.pop_front();
                    if (o_product_value !== want.value) begin
                        $display("%0t: product_value expected %08h actual %08h", $time,
                                 want.value, o_product_value);
                        errors++;
                    end
                    if (o_product_index !== want.index) begin
                        $display("%0t: product_index expected %0d actual %0d", $time,
                                 want.index, o_product_index);
                        errors++;
                    end
                    if (o_is_last !== want.last) begin
                        $display("%0t: is_last expected %0b actual %0b", $time,
                                 want.last, o_is_last);
                        errors++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                operand_copy[load_pos] = i_element_value;
                if (load_pos == mm4_pkg::POS_LAST) begin
                    for (int i = 0; i < 16; i++) begin
                        want.value = dot_row_col(i / ROW_STRIDE, i % ROW_STRIDE);
                        want.index = mm4_pkg::IDX_W'(i);
                        want.last = (mm4_pkg::IDX_W'(i) == mm4_pkg::IDX_LAST);
                        expected_products.push_back(want);
                    end
                end
                load_pos = load_pos + 1'b1;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // sender: bursts of items with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // hold the stalled item
        end else if (gap_left > 0) begin
            i_valid <= 1'b0;
            gap_left--;
        end else if (element_queue.size() > 0) begin
            i_valid <= 1'b1;
            i_element_value <= element_queue.pop_front();
            if (burst_left <= 1) begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
                burst_left--;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver: changing stall pattern, one long hold-off
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    int  stall_mode = 0;
    int  mode_left = 0;

    always @(negedge i_clk) begin
        if (!long_hold_done && products_seen >= 40) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 1) == 1);
                default: i_stall <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    initial begin
        t_fill_mode mode;
        // directed pair: saturation both ways, identity row, rounding toward minus infinity
        for (int k = 0; k < 4; k++) begin
            element_queue.push_back(mm4_pkg::SAT_MIN);
        end
        element_queue.push_back(ONE_Q);
        for (int k = 1; k < 4; k++) begin
            element_queue.push_back('0);
        end
        for (int k = 0; k < 4; k++) begin
            element_queue.push_back(MINUS_LSB);
        end
        for (int k = 0; k < 4; k++) begin
            element_queue.push_back(mm4_pkg::SAT_MAX);
        end
        for (int k = 0; k < 4; k++) begin
            element_queue.push_back(mm4_pkg::SAT_MIN);
            element_queue.push_back(mm4_pkg::SAT_MAX);
            element_queue.push_back(32'd1);
            element_queue.push_back('0);
        end
        for (int p = 0; p < PAIRS_RANDOM; p++) begin
            for (int m = 0; m < 2; m++) begin
                mode = t_fill_mode'($urandom_range(0, 4));
                for (int e = 0; e < 16; e++) begin
                    element_queue.push_back(random_element(mode));
                end
            end
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (element_queue.size() != 0 || i_valid || expected_products.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
